@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL of the demon exchange core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while aresetn is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds through reset
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/dees_pkg.sv @@
// ----------------------------------------------------------------------------
// dees_pkg
// Widths, limits and operation codes of the demon exchange core
// ----------------------------------------------------------------------------
`default_nettype none

package dees_pkg;

    // field widths
    localparam int IDX_W    = 6;
    localparam int VEL_W    = 21;
    localparam int DV_W     = 19;
    localparam int DEMON_W  = 23;
    localparam int TDATA_W  = 48;

    // datapath widths
    localparam int ALU_W    = 25;  // shared adder, covers demon minus energy change
    localparam int DIFF_W   = 19;  // v_new - v_old
    localparam int SUMV_W   = 22;  // v_new + v_old
    localparam int PROD_W   = DIFF_W + SUMV_W;
    localparam int DE_W     = 23;  // energy change, signed
    localparam int FRAC_SH  = 17;  // square to Q16 and halve

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRIAL = 1'b1;

    // limits
    localparam int VEL_MAX   = 1048575;
    localparam int VEL_MIN   = -1048576;
    localparam int DV_LIMIT  = 131072;
    localparam int DEMON_MAX = 8388607;

    localparam logic signed [ALU_W-1:0] ALU_VEL_MAX = ALU_W'(VEL_MAX);
    localparam logic signed [ALU_W-1:0] ALU_VEL_MIN = ALU_W'(VEL_MIN);
    localparam logic signed [DV_W-1:0]  DV_HI       = DV_W'(DV_LIMIT);
    localparam logic signed [DV_W-1:0]  DV_LO       = DV_W'(-DV_LIMIT);
    localparam logic [DEMON_W-1:0]      DEMON_SAT   = DEMON_W'(DEMON_MAX);

endpackage

`default_nettype wire

@@ hw/rtl/demon_energy_exchange_step_core.sv @@
// ----------------------------------------------------------------------------
// demon_energy_exchange_step_core
// Creutz demon exchange for an ideal gas: particle velocity store, demon
// energy register and a small sequencer around one shared adder
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | particle_index, load_velocity, velocity_chg | operation
//  m_      | out | new_velocity, demon_energy                  | accepted
//
//  a load beat passes the idle, read and finish steps; a trial beat passes
//  idle, read, add, diff, sumv, mul, scale, dec and finish, as the shared
//  adder is used five times per trial, besides the ram read, the multiply
//  and the output hand-off
//  one beat at a time: s_tready is high only while the sequencer is idle;
//  a result waiting on m_tready holds the next beat in its finishing step
//  aresetn clears the sequencer, output valid and demon energy; the
//  velocity ram has no reset and needs a load before its first trial
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module demon_energy_exchange_step_core #(
    parameter int NUM_PARTICLES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // particle_index[6], load_velocity[21], velocity_change[19]
    input  wire logic [0:0]  s_tuser,  // operation[1]
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // new_velocity[21], demon_energy[23]
    output logic [0:0]       m_tuser   // accepted[1]
);

    localparam int ADDR_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
    localparam int EXT_W  = dees_pkg::IDX_W + ADDR_W;
    localparam int ALU_W  = dees_pkg::ALU_W;
    localparam int VEL_W  = dees_pkg::VEL_W;
    localparam int DV_W   = dees_pkg::DV_W;
    localparam int DEM_W  = dees_pkg::DEMON_W;
    localparam int DE_W   = dees_pkg::DE_W;
    localparam int PROD_W = dees_pkg::PROD_W;
    localparam int SH     = dees_pkg::FRAC_SH;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_SUMV  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]                        state_reg;
    logic                              op_reg;
    logic [dees_pkg::IDX_W-1:0]        idx_reg;
    logic signed [VEL_W-1:0]           lv_reg;
    logic signed [DV_W-1:0]            dv_reg;
    logic signed [VEL_W-1:0]           vo_reg;
    logic signed [VEL_W-1:0]           vn_reg;
    logic signed [dees_pkg::DIFF_W-1:0] a_reg;
    logic signed [dees_pkg::SUMV_W-1:0] b_reg;
    logic signed [PROD_W-1:0]          prod_reg;
    logic signed [DE_W-1:0]            de_reg;
    logic [DEM_W-1:0]                  demon_reg;
    logic                              acc_reg;
    logic signed [VEL_W-1:0]           res_vel_reg;
    logic                              m_tvalid_reg;
    logic                              m_acc_reg;
    logic [VEL_W-1:0]                  m_vel_reg;
    logic [DEM_W-1:0]                  m_demon_reg;

    logic                              in_range;
    logic [EXT_W-1:0]                  idx_ext;
    logic [ADDR_W-1:0]                 ram_addr;
    logic                              ram_we;
    logic [VEL_W-1:0]                  ram_wdata;
    logic [VEL_W-1:0]                  ram_rdata;
    logic signed [DV_W-1:0]            s_dv;
    logic signed [DV_W-1:0]            s_dv_sat;
    logic signed [ALU_W-1:0]           alu_a;
    logic signed [ALU_W-1:0]           alu_b;
    logic                              alu_sub;
    logic signed [ALU_W-1:0]           alu_y;
    logic                              take;
    logic                              out_free;

    // handshake
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_acc_reg;
    assign m_tdata  = {(dees_pkg::TDATA_W - VEL_W - DEM_W)'(0), m_demon_reg, m_vel_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    // clamp the trial change to plus or minus two
    assign s_dv     = s_tdata[45:27];
    assign s_dv_sat = (s_dv > dees_pkg::DV_HI) ? dees_pkg::DV_HI :
                      (s_dv < dees_pkg::DV_LO) ? dees_pkg::DV_LO : s_dv;

    // particle address and range check
    assign idx_ext  = EXT_W'(idx_reg);
    assign ram_addr = idx_ext[ADDR_W-1:0];
    assign in_range = (32'(idx_reg) < 32'(NUM_PARTICLES));

    // shared adder operand selection
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_ADD: begin
                alu_a = ALU_W'($signed(ram_rdata));
                alu_b = ALU_W'(dv_reg);
            end
            S_DIFF: begin
                alu_a   = ALU_W'(vn_reg);
                alu_b   = ALU_W'(vo_reg);
                alu_sub = 1'b1;
            end
            S_SUMV: begin
                alu_a = ALU_W'(vn_reg);
                alu_b = ALU_W'(vo_reg);
            end
            S_SCALE: begin
                // truncate toward zero: round up a negative product with lost bits
                alu_a = ALU_W'(prod_reg[PROD_W-1:SH]);
                alu_b = ALU_W'({1'b0, prod_reg[PROD_W-1] && (prod_reg[SH-1:0] != '0)});
            end
            S_DEC: begin
                alu_a   = ALU_W'({1'b0, demon_reg});
                alu_b   = ALU_W'(de_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

    // a nonzero change that the demon covers, or a fall
    assign take = (de_reg != '0) && !alu_y[ALU_W-1];

    // velocity ram write port
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = vn_reg;
        if (state_reg == S_READ && op_reg == dees_pkg::OP_LOAD && in_range) begin
            ram_we    = 1'b1;
            ram_wdata = lv_reg;
        end else if (state_reg == S_DEC && take) begin
            ram_we    = 1'b1;
            ram_wdata = vn_reg;
        end
    end

    dees_ram #(
        .WIDTH (VEL_W),
        .DEPTH (NUM_PARTICLES)
    ) u_vel_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // sequencer and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            demon_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // result valid: raised on hand-off, dropped once taken
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    if (op_reg == dees_pkg::OP_TRIAL && in_range) begin
                        state_reg <= S_ADD;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_ADD:   state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_SUMV;
                S_SUMV:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_DEC;
                S_DEC: begin
                    if (take) begin
                        if (alu_y[ALU_W-1:DEM_W] != '0) begin
                            demon_reg <= dees_pkg::DEMON_SAT;
                        end else begin
                            demon_reg <= alu_y[DEM_W-1:0];
                        end
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                op_reg  <= s_tuser[0];
                idx_reg <= s_tdata[5:0];
                lv_reg  <= s_tdata[26:6];
                dv_reg  <= s_dv_sat;
            end
            S_READ: begin
                acc_reg     <= (op_reg == dees_pkg::OP_LOAD) && in_range;
                res_vel_reg <= in_range ? lv_reg : '0;
            end
            S_ADD: begin
                vo_reg <= ram_rdata;
                if (alu_y > dees_pkg::ALU_VEL_MAX) begin
                    vn_reg <= VEL_W'(dees_pkg::ALU_VEL_MAX);
                end else if (alu_y < dees_pkg::ALU_VEL_MIN) begin
                    vn_reg <= VEL_W'(dees_pkg::ALU_VEL_MIN);
                end else begin
                    vn_reg <= alu_y[VEL_W-1:0];
                end
            end
            S_DIFF:  a_reg    <= alu_y[dees_pkg::DIFF_W-1:0];
            S_SUMV:  b_reg    <= alu_y[dees_pkg::SUMV_W-1:0];
            S_MUL:   prod_reg <= a_reg * b_reg;
            S_SCALE: de_reg   <= alu_y[DE_W-1:0];
            S_DEC: begin
                acc_reg     <= take;
                res_vel_reg <= take ? vn_reg : vo_reg;
            end
            S_FIN: begin
                if (out_free) begin
                    m_acc_reg   <= acc_reg;
                    m_vel_reg   <= res_vel_reg;
                    m_demon_reg <= demon_reg;
                end
            end
            default: begin
                op_reg <= op_reg;
            end
        endcase
    end

    // checks
    `ASSERT_CLK(a_accept_starts_read, (s_tvalid && s_tready) |=> (state_reg == S_READ), "accepted beat did not start a read")
    `ASSERT_CLK(a_demon_only_in_dec, (state_reg != S_DEC) |=> $stable(demon_reg), "demon energy changed outside the decide step")
    `ASSERT_CLK(a_ram_write_steps, ram_we |-> (state_reg == S_READ || state_reg == S_DEC), "velocity write outside load or decide step")
    `ASSERT_CLK(a_result_from_fin, $rose(m_tvalid) |-> $past(state_reg == S_FIN), "result raised without finishing step")

endmodule

`default_nettype wire

@@ hw/rtl/dees_ram.sv @@
// ----------------------------------------------------------------------------
// dees_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dees_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
